// ----- rtl/ilsu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilsu_pkg
// Shared types and constants for the indexed list store unit.
// ----------------------------------------------------------------------------
package ilsu_pkg;

  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_ELEM_WIDTH = 32;

  // fixed port field widths
  localparam int OPCODE_W   = 3;
  localparam int POS_W      = 7;
  localparam int ELEM_IO_W  = 32;
  localparam int STATUS_W   = 2;
  localparam int COUNT_IO_W = 7;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_GET    = 3'd2,
    OP_SET    = 3'd3,
    OP_INSERT = 3'd4,
    OP_REMOVE = 3'd5
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_GRAB,
    S_SHIFT,
    S_DRAIN,
    S_FINAL,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_TOP,
    RD_POS,
    RD_IDX
  } rd_sel_t;

  typedef enum logic {
    WR_AT_COUNT,
    WR_AT_POS
  } wr_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;      // capture a new request
    rd_sel_t rd_sel;    // RAM read address source
    logic    wr_en;     // write the request element
    wr_sel_t wr_sel;    // where the request element goes
    logic    idx_init;  // start the shift index
    logic    shift_rd;  // read one shift source, write it back next cycle
    logic    capture;   // latch RAM read data as the result element
    logic    commit;    // update count and load the result register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    status_t             status;
    logic                pos_eq_cnt;   // position == count
    logic                pos_eq_last;  // position == count - 1
    logic                idx_last;     // shift index at its final element
    logic                out_free;     // result register can take a result
  } dp_stat_t;

endpackage

// ----- rtl/ilsu_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilsu_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ilsu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/ilsu_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilsu_dp
// Datapath: request registers, element count, element RAM, shift pipeline
// and result register.
// ----------------------------------------------------------------------------
module ilsu_dp import ilsu_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [OPCODE_W-1:0]   in_opcode,
  input  logic [POS_W-1:0]      in_position,
  input  logic [ELEM_IO_W-1:0]  in_element_in,
  input  logic                  out_ready,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   out_status,
  output logic [ELEM_IO_W-1:0]  out_element_out,
  output logic [COUNT_IO_W-1:0] out_count_after
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [OPCODE_W-1:0]   op_r, op_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [ELEM_WIDTH-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic                  wpend_r, wpend_nxt;
  logic [AW-1:0]         waddr_r, waddr_nxt;
  logic [ELEM_WIDTH-1:0] got_r, got_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [ELEM_IO_W-1:0]  out_elem_r, out_elem_nxt;
  logic [COUNT_IO_W-1:0] out_count_r, out_count_nxt;

  logic [CMP_W-1:0]      pos_x, cnt_x;
  logic [AW-1:0]         pos_addr, top_addr;
  status_t               status;
  logic                  is_ins;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [ELEM_WIDTH-1:0] ram_wdata, ram_rdata;

  assign pos_x    = CMP_W'(pos_r);
  assign cnt_x    = CMP_W'(count_r);
  assign pos_addr = AW'(pos_r);
  assign top_addr = AW'(count_r - 1'b1);
  assign is_ins   = (op_r == OP_INSERT);

  // request status; insert checks position before capacity
  always_comb begin
    unique case (op_r)
      OP_PUSH:   status = (count_r == CAP_CNT) ? ST_FULL : ST_OK;
      OP_POP:    status = (count_r == '0) ? ST_EMPTY : ST_OK;
      OP_GET,
      OP_SET,
      OP_REMOVE: status = (pos_x >= cnt_x) ? ST_BAD_INDEX : ST_OK;
      OP_INSERT: begin
        if (pos_x > cnt_x) begin
          status = ST_BAD_INDEX;
        end else if (count_r == CAP_CNT) begin
          status = ST_FULL;
        end else begin
          status = ST_OK;
        end
      end
      default:   status = ST_BAD_INDEX;
    endcase
  end

  assign stat.op          = op_r;
  assign stat.status      = status;
  assign stat.pos_eq_cnt  = (pos_x == cnt_x);
  assign stat.pos_eq_last = ((pos_x + CMP_W'(1)) == cnt_x);
  assign stat.idx_last    = is_ins ? (idx_r == pos_addr) : (idx_r == top_addr);
  assign stat.out_free    = !out_valid_r || out_ready;

  // RAM ports; a pending shift write never meets a request-element write
  always_comb begin
    unique case (cmd.rd_sel)
      RD_TOP:  ram_raddr = top_addr;
      RD_POS:  ram_raddr = pos_addr;
      RD_IDX:  ram_raddr = idx_r;
      default: ram_raddr = idx_r;
    endcase
    if (wpend_r) begin
      ram_we    = 1'b1;
      ram_waddr = waddr_r;
      ram_wdata = ram_rdata;
    end else begin
      ram_we    = cmd.wr_en;
      ram_waddr = (cmd.wr_sel == WR_AT_POS) ? pos_addr : AW'(count_r);
      ram_wdata = val_r;
    end
  end

  ilsu_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    op_nxt  = cmd.load ? in_opcode : op_r;
    pos_nxt = cmd.load ? in_position : pos_r;
    val_nxt = cmd.load ? ELEM_WIDTH'(in_element_in) : val_r;

    // insert walks down from the top, remove walks up from position + 1
    idx_nxt = idx_r;
    if (cmd.idx_init) begin
      idx_nxt = is_ins ? top_addr : AW'(pos_x + CMP_W'(1));
    end else if (cmd.shift_rd) begin
      idx_nxt = is_ins ? (idx_r - 1'b1) : (idx_r + 1'b1);
    end
    wpend_nxt = cmd.shift_rd;
    waddr_nxt = is_ins ? (idx_r + 1'b1) : (idx_r - 1'b1);

    got_nxt = got_r;
    if (cmd.load) begin
      got_nxt = '0;
    end else if (cmd.capture) begin
      got_nxt = ram_rdata;
    end

    count_nxt = count_r;
    if (cmd.commit && status == ST_OK) begin
      if (op_r == OP_PUSH || op_r == OP_INSERT) begin
        count_nxt = count_r + 1'b1;
      end else if (op_r == OP_POP || op_r == OP_REMOVE) begin
        count_nxt = count_r - 1'b1;
      end
    end

    out_valid_nxt  = cmd.commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    out_status_nxt = cmd.commit ? status : out_status_r;
    out_elem_nxt   = cmd.commit ? ELEM_IO_W'(got_r) : out_elem_r;
    out_count_nxt  = cmd.commit ? COUNT_IO_W'(count_nxt) : out_count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      wpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      wpend_r     <= wpend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    waddr_r      <= waddr_nxt;
    got_r        <= got_nxt;
    out_status_r <= out_status_nxt;
    out_elem_r   <= out_elem_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_element_out = out_elem_r;
  assign out_count_after = out_count_r;

endmodule

// ----- rtl/ilsu_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilsu_ctrl
// Controller FSM: sequences evaluation, RAM access, shifting and result hand-off.
// ----------------------------------------------------------------------------
module ilsu_ctrl import ilsu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   ok;

  assign ok = (stat.status == ST_OK);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!ok) begin
          state_nxt = S_DONE;
        end else begin
          unique case (stat.op)
            OP_POP,
            OP_GET,
            OP_REMOVE: state_nxt = S_GRAB;
            OP_INSERT: state_nxt = stat.pos_eq_cnt ? S_DONE : S_SHIFT;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_GRAB: begin
        state_nxt = (stat.op == OP_REMOVE && !stat.pos_eq_last) ? S_SHIFT : S_DONE;
      end
      S_SHIFT: begin
        if (stat.idx_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = (stat.op == OP_INSERT) ? S_FINAL : S_DONE;
      S_FINAL: state_nxt = S_DONE;
      S_DONE: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.rd_sel = RD_IDX;
    cmd.wr_sel = WR_AT_POS;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EVAL: begin
        if (ok) begin
          unique case (stat.op)
            OP_PUSH: begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = WR_AT_COUNT;
            end
            OP_POP:  cmd.rd_sel = RD_TOP;
            OP_GET:  cmd.rd_sel = RD_POS;
            OP_SET:  cmd.wr_en  = 1'b1;
            OP_INSERT: begin
              cmd.wr_en    = stat.pos_eq_cnt;
              cmd.idx_init = !stat.pos_eq_cnt;
            end
            OP_REMOVE: begin
              cmd.rd_sel   = RD_POS;
              cmd.idx_init = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_GRAB:  cmd.capture  = 1'b1;
      S_SHIFT: cmd.shift_rd = 1'b1;
      S_DRAIN: ;
      S_FINAL: cmd.wr_en    = 1'b1;
      S_DONE:  cmd.commit   = stat.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/indexed_list_store_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_store_unit
// Bounded ordered list with push, pop, get, set, insert-at and remove-at.
// Push, set, append-insert and errors go from evaluation straight to the result;
// pop, get and remove of the last element first read one element; other removes
// read it and then shift the elements above down, and insert shifts them up.
// Moves are bound by the element RAM's single write port: one element a cycle.
// One transaction in flight; the next is taken in the cycle after the result is queued.
// Synchronous active-low reset empties the list; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module indexed_list_store_unit import ilsu_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OPCODE_W-1:0]   in_opcode,
  input  logic [POS_W-1:0]      in_position,
  input  logic [ELEM_IO_W-1:0]  in_element_in,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   out_status,
  output logic [ELEM_IO_W-1:0]  out_element_out,
  output logic [COUNT_IO_W-1:0] out_count_after
);

  // Command and status between controller and datapath.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Controller: IDLE takes a transaction, EVAL classifies it and issues the
  // first RAM access, GRAB latches read data, SHIFT streams elements one slot
  // up (insert) or down (remove), DRAIN retires the last shift write, FINAL
  // places the inserted element, DONE hands the result to the output register.
  ilsu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: request registers, count, element RAM, shift pipeline and the
  // result register, which lets a new transaction start while a result waits.
  ilsu_dp #(
    .CAPACITY   (CAPACITY),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_opcode       (in_opcode),
    .in_position     (in_position),
    .in_element_in   (in_element_in),
    .out_ready       (out_ready),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_element_out (out_element_out),
    .out_count_after (out_count_after)
  );

  // A failed request never returns an element.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_element_out == '0))
    else $error("failed request returned a nonzero element");

  // Only one transaction is worked on at a time.
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request port stayed ready after a transaction");

  // A result is only committed when the result register is free.
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> stat.out_free)
    else $error("result committed over a pending result");

  // A committed result shows up on the result channel next cycle.
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

endmodule
